// ----- design/cle_pkg.sv -----
// ----------------------------------------------------------------------------
// cle_pkg: shared types and constants of the console line editor
// Key codes, command and line-end codes, and the beat payload structs.
// ----------------------------------------------------------------------------
package cle_pkg;

  // Command codes of an input beat
  localparam logic CMD_RX  = 1'b0;  // received character
  localparam logic CMD_POP = 1'b1;  // reader pops one byte

  // Control keys
  localparam logic [7:0] KEY_NUL  = 8'h00;
  localparam logic [7:0] KEY_EOF  = 8'h04;  // Ctrl-D
  localparam logic [7:0] KEY_BS   = 8'h08;  // Ctrl-H
  localparam logic [7:0] KEY_LF   = 8'h0A;
  localparam logic [7:0] KEY_CR   = 8'h0D;
  localparam logic [7:0] KEY_DUMP = 8'h10;  // Ctrl-P
  localparam logic [7:0] KEY_KILL = 8'h15;  // Ctrl-U
  localparam logic [7:0] KEY_DEL  = 8'h7F;

  // Line-end codes reported with a pop
  localparam logic [1:0] END_CONT = 2'd0;
  localparam logic [1:0] END_LINE = 2'd1;
  localparam logic [1:0] END_EOF  = 2'd2;
  localparam logic [1:0] END_NONE = 2'd3;

  // Erase count saturates here
  localparam logic [7:0] ERASE_MAX = 8'd255;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_char;
    logic       first_of_read;
  } cle_item_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       dump_request;
    logic       line_ready;
    logic       read_valid;
    logic [7:0] read_char;
    logic [1:0] read_end;
  } cle_result_t;

endpackage

// ----- design/cle_if.sv -----
// ----------------------------------------------------------------------------
// cle_if: valid/ready channels of the console line editor
// Input channel (character or pop request) and result channel.
// ----------------------------------------------------------------------------
interface cle_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_char;
  logic       first_of_read;

  modport source (output valid, cmd, rx_char, first_of_read, input ready);
  modport sink   (input valid, cmd, rx_char, first_of_read, output ready);
endinterface

interface cle_out_if;
  logic       valid;
  logic       ready;
  logic       echo_valid;
  logic [7:0] echo_char;
  logic [7:0] erase_count;
  logic       dump_request;
  logic       line_ready;
  logic       read_valid;
  logic [7:0] read_char;
  logic [1:0] read_end;

  modport source (output valid, echo_valid, echo_char, erase_count, dump_request,
                  line_ready, read_valid, read_char, read_end, input ready);
  modport sink   (input valid, echo_valid, echo_char, erase_count, dump_request,
                  line_ready, read_valid, read_char, read_end, output ready);
endinterface

// ----- design/cle_ram.sv -----
// ----------------------------------------------------------------------------
// cle_ram: generic single-write, single-read synchronous RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/cle_seq.sv -----
// ----------------------------------------------------------------------------
// cle_seq: line editor sequencer
// Holds the read, commit and edit indices and runs each beat against the
// line store: store, erase, kill-line walk and pop.
// ----------------------------------------------------------------------------
module cle_seq #(
  parameter int BUF_DEPTH = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // item side
  input  logic                         item_valid,
  output logic                         item_ready,
  input  cle_pkg::cle_item_t           item,
  // line store
  output logic                         mem_we,
  output logic [$clog2(BUF_DEPTH)-1:0] mem_waddr,
  output logic [7:0]                   mem_wdata,
  output logic                         mem_re,
  output logic [$clog2(BUF_DEPTH)-1:0] mem_raddr,
  input  logic [7:0]                   mem_rdata,
  // result side
  output logic                         res_valid,
  input  logic                         res_take,
  output cle_pkg::cle_result_t         res
);

  localparam int IdxRange = 2 * BUF_DEPTH;
  localparam int IW       = $clog2(IdxRange);
  localparam int AW       = $clog2(BUF_DEPTH);
  localparam logic [IW-1:0] IdxLast = IW'(IdxRange - 1);
  localparam logic [IW-1:0] Depth   = IW'(BUF_DEPTH);
  localparam logic [IW:0]   Range1  = (IW + 1)'(IdxRange);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_POP  = 5'b00100,
    S_KILL = 5'b01000,
    S_DONE = 5'b10000
  } seq_state_t;

  // Index arithmetic, indices run modulo twice the depth
  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] x);
    return (x == IdxLast) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] x);
    return (x == '0) ? IdxLast : x - 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dist(input logic [IW-1:0] a,
                                             input logic [IW-1:0] b);
    logic [IW:0] d;
    d = (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + Range1 - {1'b0, b});
    return d[IW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot(input logic [IW-1:0] x);
    logic [IW-1:0] s;
    s = (x >= Depth) ? x - Depth : x;
    return s[AW-1:0];
  endfunction

  seq_state_t           state_r, state_nxt;
  cle_pkg::cle_item_t   item_r, item_nxt;
  cle_pkg::cle_result_t res_r, res_nxt;
  logic [IW-1:0]        read_r, read_nxt;
  logic [IW-1:0]        commit_r, commit_nxt;
  logic [IW-1:0]        edit_r, edit_nxt;

  logic [IW-1:0] edit_inc, edit_dec, edit_dec2;
  logic [7:0]    store_char;
  logic          has_room;
  logic          commit_hit;

  assign edit_inc   = idx_inc(edit_r);
  assign edit_dec   = idx_dec(edit_r);
  assign edit_dec2  = idx_dec(edit_dec);
  assign store_char = (item_r.rx_char == cle_pkg::KEY_CR) ? cle_pkg::KEY_LF : item_r.rx_char;
  assign has_room   = idx_dist(edit_r, read_r) < Depth;
  assign commit_hit = (store_char == cle_pkg::KEY_LF) || (store_char == cle_pkg::KEY_EOF) ||
                      (idx_dist(edit_inc, read_r) == Depth);

  assign item_ready = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_DONE);
  assign res        = res_r;

  // Sequencer: one store access per cycle, read data comes from the store's registered read port
  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    res_nxt    = res_r;
    read_nxt   = read_r;
    commit_nxt = commit_r;
    edit_nxt   = edit_r;
    mem_we     = 1'b0;
    mem_waddr  = slot(edit_r);
    mem_wdata  = store_char;
    mem_re     = 1'b0;
    mem_raddr  = slot(read_r);

    case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          item_nxt  = item;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        res_nxt   = '0;
        state_nxt = S_DONE;
        if (item_r.cmd == cle_pkg::CMD_RX) begin
          case (item_r.rx_char)
            cle_pkg::KEY_DUMP: begin
              res_nxt.dump_request = 1'b1;
            end
            cle_pkg::KEY_KILL: begin
              // walk back from the slot before the edit point
              if (edit_r != commit_r) begin
                mem_re    = 1'b1;
                mem_raddr = slot(edit_dec);
                state_nxt = S_KILL;
              end
            end
            cle_pkg::KEY_BS, cle_pkg::KEY_DEL: begin
              if (edit_r != commit_r) begin
                edit_nxt            = edit_dec;
                res_nxt.erase_count = 8'd1;
              end
            end
            default: begin
              // ordinary byte: echo and store unless null or store full
              if (item_r.rx_char != cle_pkg::KEY_NUL && has_room) begin
                mem_we             = 1'b1;
                res_nxt.echo_valid = 1'b1;
                res_nxt.echo_char  = store_char;
                edit_nxt           = edit_inc;
                if (commit_hit) begin
                  commit_nxt         = edit_inc;
                  res_nxt.line_ready = 1'b1;
                end
              end
            end
          endcase
        end else if (read_r == commit_r) begin
          res_nxt.read_end = cle_pkg::END_NONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = slot(read_r);
          state_nxt = S_POP;
        end
      end

      S_POP: begin
        state_nxt = S_DONE;
        if (mem_rdata == cle_pkg::KEY_EOF) begin
          // EOF is consumed only at the start of a read
          if (item_r.first_of_read) begin
            read_nxt = idx_inc(read_r);
          end
          res_nxt.read_end = cle_pkg::END_EOF;
        end else begin
          read_nxt           = idx_inc(read_r);
          res_nxt.read_valid = 1'b1;
          res_nxt.read_char  = mem_rdata;
          res_nxt.read_end   = (mem_rdata == cle_pkg::KEY_LF) ? cle_pkg::END_LINE
                                                               : cle_pkg::END_CONT;
        end
      end

      S_KILL: begin
        // one slot per cycle; stop at a newline or the commit point
        if (mem_rdata == cle_pkg::KEY_LF) begin
          state_nxt = S_DONE;
        end else begin
          edit_nxt = edit_dec;
          if (res_r.erase_count != cle_pkg::ERASE_MAX) begin
            res_nxt.erase_count = res_r.erase_count + 8'd1;
          end
          if (edit_dec == commit_r) begin
            state_nxt = S_DONE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = slot(edit_dec2);
          end
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      read_r   <= '0;
      commit_r <= '0;
      edit_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      read_r   <= read_nxt;
      commit_r <= commit_nxt;
      edit_r   <= edit_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

endmodule

// ----- design/console_line_editor.sv -----
// ----------------------------------------------------------------------------
// console_line_editor: canonical console line editor
// Ring-buffer line discipline with erase, kill-line, dump and read pops.
// ----------------------------------------------------------------------------
// One beat is handled at a time. A beat is taken when the sequencer is idle,
// even while the previous result still sits in the output register. A
// character, an erase, a dump or an empty pop goes through the execute and
// done states; a pop that reads the line store adds a pop state between them.
// Kill-line walks the store backwards through its single read port one slot
// per cycle until a newline or the commit point stops it. The line store
// holds BUF_DEPTH bytes in one RAM and needs no clearing after reset; only
// the indices, the sequencer state and the output valid flag are reset.
module console_line_editor #(
  parameter int BUF_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  cle_in_if.sink     in_ch,
  cle_out_if.source  out_ch
);

  localparam int AW = $clog2(BUF_DEPTH);

  cle_pkg::cle_item_t   item;
  cle_pkg::cle_result_t res;
  cle_pkg::cle_result_t out_r;
  logic                 res_valid;
  logic                 res_take;
  logic                 out_valid_r;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [7:0]           mem_wdata, mem_rdata;

  assign item.cmd           = in_ch.cmd;
  assign item.rx_char       = in_ch.rx_char;
  assign item.first_of_read = in_ch.first_of_read;

  cle_seq #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_ch.valid),
    .item_ready (in_ch.ready),
    .item       (item),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  cle_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: loads when empty or being drained
  assign res_take = res_valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.echo_valid   = out_r.echo_valid;
  assign out_ch.echo_char    = out_r.echo_char;
  assign out_ch.erase_count  = out_r.erase_count;
  assign out_ch.dump_request = out_r.dump_request;
  assign out_ch.line_ready   = out_r.line_ready;
  assign out_ch.read_valid   = out_r.read_valid;
  assign out_ch.read_char    = out_r.read_char;
  assign out_ch.read_end     = out_r.read_end;

endmodule

// ----- tb/console_line_editor_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_line_editor_test: self-checking bench for the console line editor
// Drives character and pop beats with random gaps, predicts each result from
// a private copy of the ring store and its indices, and checks every result
// beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module console_line_editor_test;

  localparam int STORE_DEPTH = 128;
  localparam int SLOT_W      = $clog2(STORE_DEPTH);

  // Line discipline predictor plus the queue of results still owed
  class line_scoreboard;
    logic [7:0]           store_copy [STORE_DEPTH];
    int unsigned          rd_idx;
    int unsigned          commit_idx;
    int unsigned          edit_idx;
    cle_pkg::cle_result_t owed_results [$];
    int                   errors;
    int                   results_seen;

    function new();
      rd_idx       = 0;
      commit_idx   = 0;
      edit_idx     = 0;
      errors       = 0;
      results_seen = 0;
    endfunction

    // Indices run modulo twice the depth so full and empty differ
    function int unsigned idx_next(int unsigned x);
      return (x + 1) % (2 * STORE_DEPTH);
    endfunction

    function int unsigned idx_prev(int unsigned x);
      return (x + 2 * STORE_DEPTH - 1) % (2 * STORE_DEPTH);
    endfunction

    function int unsigned span(int unsigned a, int unsigned b);
      return (a + 2 * STORE_DEPTH - b) % (2 * STORE_DEPTH);
    endfunction

    // Store slot of an index
    function logic [SLOT_W-1:0] slot_of(int unsigned x);
      return SLOT_W'(x % STORE_DEPTH);
    endfunction

    function int unsigned committed_bytes();
      return span(commit_idx, rd_idx);
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Apply one input beat to the private state and return its result
    function cle_pkg::cle_result_t predict_result(cle_pkg::cle_item_t it);
      cle_pkg::cle_result_t r;
      logic [7:0]           ch;
      int unsigned          n;
      r = '0;
      if (it.cmd == cle_pkg::CMD_RX) begin
        ch = it.rx_char;
        if (ch == cle_pkg::KEY_DUMP) begin
          r.dump_request = 1'b1;
        end else if (ch == cle_pkg::KEY_KILL) begin
          n = 0;
          while (edit_idx != commit_idx &&
                 store_copy[slot_of(idx_prev(edit_idx))] != cle_pkg::KEY_LF) begin
            edit_idx = idx_prev(edit_idx);
            n++;
          end
          r.erase_count = (n > 255) ? cle_pkg::ERASE_MAX : n[7:0];
        end else if (ch == cle_pkg::KEY_BS || ch == cle_pkg::KEY_DEL) begin
          if (edit_idx != commit_idx) begin
            edit_idx      = idx_prev(edit_idx);
            r.erase_count = 8'd1;
          end
        end else if (ch != cle_pkg::KEY_NUL && span(edit_idx, rd_idx) < STORE_DEPTH) begin
          if (ch == cle_pkg::KEY_CR) ch = cle_pkg::KEY_LF;
          r.echo_valid = 1'b1;
          r.echo_char  = ch;
          store_copy[slot_of(edit_idx)] = ch;
          edit_idx = idx_next(edit_idx);
          if (ch == cle_pkg::KEY_LF || ch == cle_pkg::KEY_EOF ||
              span(edit_idx, rd_idx) == STORE_DEPTH) begin
            commit_idx   = edit_idx;
            r.line_ready = 1'b1;
          end
        end
        // zero byte or full store: nothing happens
      end else begin
        if (rd_idx == commit_idx) begin
          r.read_end = cle_pkg::END_NONE;
        end else begin
          ch = store_copy[slot_of(rd_idx)];
          if (ch == cle_pkg::KEY_EOF) begin
            // EOF is consumed only by the first pop of a read
            if (it.first_of_read) rd_idx = idx_next(rd_idx);
            r.read_end = cle_pkg::END_EOF;
          end else begin
            rd_idx      = idx_next(rd_idx);
            r.read_valid = 1'b1;
            r.read_char  = ch;
            r.read_end   = (ch == cle_pkg::KEY_LF) ? cle_pkg::END_LINE : cle_pkg::END_CONT;
          end
        end
      end
      return r;
    endfunction

    // Returns 1 when the beat had any visible effect
    function bit note_beat(cle_pkg::cle_item_t it);
      cle_pkg::cle_result_t r;
      r = predict_result(it);
      owed_results.push_back(r);
      return r != '0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task compare_field(string name, int got, int want);
      if (got != want)
        report($sformatf("result %0d %s got 0x%0h expected 0x%0h",
                         results_seen, name, got, want));
    endtask

    task check_result(cle_pkg::cle_result_t got);
      cle_pkg::cle_result_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing owed", results_seen));
      end else begin
        want = owed_results.pop_front();
        compare_field("echo_valid",   int'(got.echo_valid),   int'(want.echo_valid));
        compare_field("echo_char",    int'(got.echo_char),    int'(want.echo_char));
        compare_field("erase_count",  int'(got.erase_count),  int'(want.erase_count));
        compare_field("dump_request", int'(got.dump_request), int'(want.dump_request));
        compare_field("line_ready",   int'(got.line_ready),   int'(want.line_ready));
        compare_field("read_valid",   int'(got.read_valid),   int'(want.read_valid));
        compare_field("read_char",    int'(got.read_char),    int'(want.read_char));
        compare_field("read_end",     int'(got.read_end),     int'(want.read_end));
      end
      results_seen++;
    endtask

    task flush_leftovers();
      if (owed_results.size() != 0)
        report($sformatf("%0d results never arrived", owed_results.size()));
    endtask
  endclass

  logic clk;
  logic rst_n;

  cle_in_if  in_ch();
  cle_out_if out_ch();

  console_line_editor #(
    .BUF_DEPTH(STORE_DEPTH)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  line_scoreboard sb = new();

  bit steady_in;
  bit steady_out;
  int useful_beats;
  int sent_beats;

  // Clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Idle length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Send one beat and wait for its acceptance
  task automatic send_beat(input logic cmd_v, input logic [7:0] ch_v, input logic first_v);
    int                 gap;
    cle_pkg::cle_item_t it;
    gap = steady_in ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= cmd_v;
    in_ch.rx_char       <= ch_v;
    in_ch.first_of_read <= first_v;
    do @(posedge clk); while (!in_ch.ready);
    it.cmd           = cmd_v;
    it.rx_char       = ch_v;
    it.first_of_read = first_v;
    sent_beats++;
    if (sb.note_beat(it)) useful_beats++;
  endtask

  task automatic type_char(input logic [7:0] ch);
    send_beat(cle_pkg::CMD_RX, ch, 1'($urandom_range(0, 1)));
  endtask

  task automatic pop(input logic first_v);
    send_beat(cle_pkg::CMD_POP, 8'($urandom_range(0, 255)), first_v);
  endtask

  // A typed line with random content and occasional edits
  task automatic type_line();
    int len;
    int r;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 140) : $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5) type_char(cle_pkg::KEY_BS);
      else if (r < 8) type_char(cle_pkg::KEY_DEL);
      else if (r < 10) type_char(cle_pkg::KEY_KILL);
      else if (r < 12) type_char(cle_pkg::KEY_DUMP);
      else if (r < 70) type_char(8'($urandom_range(8'h20, 8'h7E)));
      else type_char(8'($urandom_range(1, 255)));
    end
    r = $urandom_range(0, 99);
    if (r < 45) type_char(cle_pkg::KEY_CR);
    else if (r < 75) type_char(cle_pkg::KEY_LF);
    else if (r < 90) type_char(cle_pkg::KEY_EOF);
  endtask

  // A read call: pop what is committed, sometimes a little more
  task automatic read_call();
    int n;
    n = sb.committed_bytes() + $urandom_range(0, 2);
    if (n == 0) n = 1;
    if (n > 140) n = 140;
    for (int k = 0; k < n; k++) pop(k == 0);
  endtask

  // Result side: random stalls, checks every accepted beat
  initial begin
    int                   stall_left;
    cle_pkg::cle_result_t got;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.echo_valid   = out_ch.echo_valid;
        got.echo_char    = out_ch.echo_char;
        got.erase_count  = out_ch.erase_count;
        got.dump_request = out_ch.dump_request;
        got.line_ready   = out_ch.line_ready;
        got.read_valid   = out_ch.read_valid;
        got.read_char    = out_ch.read_char;
        got.read_end     = out_ch.read_end;
        sb.check_result(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!steady_out) stall_left = pick_gap();
      end
    end
  end

  // Stimulus
  initial begin
    int guard;
    int r;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = cle_pkg::CMD_RX;
    in_ch.rx_char       = cle_pkg::KEY_NUL;
    in_ch.first_of_read = 1'b0;
    steady_in           = 1'b0;
    steady_out          = 1'b0;
    useful_beats        = 0;
    sent_beats          = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty pop, zero byte, erases at the commit point, dump
    pop(1'b1);
    type_char(cle_pkg::KEY_NUL);
    type_char(cle_pkg::KEY_BS);
    type_char(cle_pkg::KEY_DEL);
    type_char(cle_pkg::KEY_KILL);
    type_char(cle_pkg::KEY_DUMP);
    // edits on a partial line, byte extremes
    type_char(8'h61);
    type_char(8'hFF);
    type_char(8'h80);
    type_char(cle_pkg::KEY_BS);
    type_char(cle_pkg::KEY_DEL);
    type_char(8'h62);
    type_char(cle_pkg::KEY_KILL);
    // CR becomes LF and commits; then a line ended by Ctrl-D
    type_char(8'h78);
    type_char(cle_pkg::KEY_CR);
    type_char(8'h7A);
    type_char(cle_pkg::KEY_EOF);
    // EOF after earlier bytes of a read is kept, then consumed by a new read
    pop(1'b1);
    pop(1'b0);
    pop(1'b0);
    pop(1'b0);
    pop(1'b1);
    pop(1'b1);

    // Random: mostly typed lines and read calls, some noise
    while (useful_beats < 900 && sent_beats < 4000) begin
      if ($urandom_range(0, 19) == 0) steady_in = ~steady_in;
      if ($urandom_range(0, 19) == 0) steady_out = ~steady_out;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        type_line();
      end else if (r < 85) begin
        read_call();
      end else begin
        repeat ($urandom_range(1, 5))
          send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
      end
    end
    in_ch.valid <= 1'b0;

    // Drain
    guard = 0;
    while (sb.pending() > 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    sb.flush_leftovers();
    if (sb.errors == 0) begin
      $display("console_line_editor_test OK");
    end else begin
      $display("console_line_editor_test NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("console_line_editor_test NOT OK");
    $finish;
  end

endmodule
